/* design/bbps_pkg.sv */
// Package with the types, constants and helper function of the buzzer beep sequencer.
package bbps_pkg;

    localparam int TICK_BITS = 10;
    localparam int REG_W = 10;
    localparam int CMP_W = ((TICK_BITS > REG_W) ? TICK_BITS : REG_W) + 1;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W = 3;
    localparam int SOUND_W = 3;

    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    localparam logic [REG_W-1:0] BEEP_RST = REG_W'(100);
    localparam logic [REG_W-1:0] SHORT_GAP_RST = REG_W'(100);
    localparam logic [REG_W-1:0] LONG_GAP_RST = REG_W'(300);
    localparam logic [REG_W-1:0] LONG_BEEP_RST = REG_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_BEEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_BEEP = 2'd3;

    localparam logic [SOUND_W-1:0] SOUND_HIGH_POWER = 3'd1;
    localparam logic [SOUND_W-1:0] SOUND_ERROR = 3'd2;
    localparam logic [SOUND_W-1:0] SOUND_LOW_POWER = 3'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        KIND_SINGLE  = 2'd0,
        KIND_ERROR   = 2'd1,
        KIND_LOWPWR  = 2'd2,
        KIND_FACTORY = 2'd3
    } kind_t;

    typedef struct packed {
        logic [REG_W-1:0] beep;
        logic [REG_W-1:0] short_gap;
        logic [REG_W-1:0] long_gap;
        logic [REG_W-1:0] long_beep;
    } cfg_t;

    typedef struct packed {
        logic                 active;
        kind_t                kind;
        logic [STEP_W-1:0]    step;
        logic [TICK_BITS-1:0] ticks_left;
        logic                 drive;
    } state_t;

    function automatic logic [TICK_BITS-1:0] clamp_ticks(input logic [REG_W-1:0] v);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        if (wide > CMP_W'(TICK_MAX))
        begin
            return TICK_MAX;
        end
        return wide[TICK_BITS-1:0];
    endfunction

endpackage

/* design/bbps_req_if.sv */
// Request channel interface carrying ticks and beep requests.
interface bbps_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [bbps_pkg::SOUND_W-1:0] sound;

    modport source (output valid, output command, output sound, input ready);
    modport sink (input valid, input command, input sound, output ready);
endinterface

/* design/bbps_rsp_if.sv */
// Result channel interface carrying one status item per request transfer.
interface bbps_rsp_if;
    logic valid;
    logic ready;
    logic accepted;
    logic buzzer_on;
    logic busy_res;

    modport source (output valid, output accepted, output buzzer_on, output busy_res,
                    input ready);
    modport sink (input valid, input accepted, input buzzer_on, input busy_res,
                  output ready);
endinterface

/* design/bbps_cfg_if.sv */
// Configuration write channel interface.
interface bbps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bbps_pkg::CFG_IDX_W-1:0] index;
    logic [bbps_pkg::REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* design/bbps_step.sv */
// Next-state logic of the sequencer for one tick or request.
module bbps_step (
    input  bbps_pkg::state_t              cur,
    input  bbps_pkg::cfg_t                cfg,
    input  logic                          command,
    input  logic [bbps_pkg::SOUND_W-1:0]  sound,
    output bbps_pkg::state_t              nxt,
    output logic                          took
);

    logic                           run;
    logic                           run_level;
    logic [bbps_pkg::REG_W-1:0]     run_len;
    logic [bbps_pkg::STEP_W-1:0]    s;

    always_comb
    begin
        s = cur.step;
        run = 1'b0;
        run_level = 1'b0;
        run_len = cfg.beep;
        unique case (cur.kind)
            bbps_pkg::KIND_SINGLE, bbps_pkg::KIND_FACTORY:
            begin
                if (s == 3'd0)
                begin
                    run = 1'b1;
                    run_level = 1'b1;
                    run_len = (cur.kind == bbps_pkg::KIND_FACTORY) ? cfg.long_beep : cfg.beep;
                end
            end
            bbps_pkg::KIND_LOWPWR:
            begin
                if (s == 3'd0 || s == 3'd2)
                begin
                    run = 1'b1;
                    run_level = 1'b1;
                end
                else if (s == 3'd1)
                begin
                    run = 1'b1;
                    run_len = cfg.short_gap;
                end
            end
            default:
            begin
                if (!s[0])
                begin
                    run = 1'b1;
                    run_level = 1'b1;
                end
                else if (s == 3'd1 || s == 3'd5)
                begin
                    run = 1'b1;
                    run_len = cfg.short_gap;
                end
                else if (s == 3'd3)
                begin
                    run = 1'b1;
                    run_len = cfg.long_gap;
                end
            end
        endcase
    end

    always_comb
    begin
        nxt = cur;
        took = 1'b0;
        if (command == bbps_pkg::CMD_REQUEST)
        begin
            if (!cur.active)
            begin
                priority if (sound <= bbps_pkg::SOUND_HIGH_POWER)
                begin
                    nxt.kind = bbps_pkg::KIND_SINGLE;
                end
                else if (sound == bbps_pkg::SOUND_ERROR)
                begin
                    nxt.kind = bbps_pkg::KIND_ERROR;
                end
                else if (sound == bbps_pkg::SOUND_LOW_POWER)
                begin
                    nxt.kind = bbps_pkg::KIND_LOWPWR;
                end
                else
                begin
                    nxt.kind = bbps_pkg::KIND_FACTORY;
                end
                nxt.active = 1'b1;
                nxt.step = '0;
                nxt.ticks_left = bbps_pkg::clamp_ticks(cfg.beep);
                took = 1'b1;
            end
        end
        else if (cur.active)
        begin
            if (cur.ticks_left <= bbps_pkg::TICK_BITS'(1))
            begin
                if (run)
                begin
                    nxt.drive = run_level;
                    nxt.ticks_left = bbps_pkg::clamp_ticks(run_len);
                    nxt.step = s + 3'd1;
                end
                else
                begin
                    nxt.drive = 1'b0;
                    nxt.active = 1'b0;
                    nxt.step = '0;
                    nxt.ticks_left = '0;
                end
            end
            else
            begin
                nxt.ticks_left = cur.ticks_left - bbps_pkg::TICK_BITS'(1);
            end
        end
    end

endmodule

/* design/buzzer_beep_pattern_sequencer_unit.sv */
// Top level of the buzzer beep pattern sequencer.
// The result of a request transfer is registered and offered in the cycle after the transfer.
// Throughput: one item per cycle while results are taken; the result register frees as it is taken.
// The state update and the result register sit behind one short step of logic.
// Reset clears the sequencer to idle with the buzzer off and loads the default lengths.
module buzzer_beep_pattern_sequencer_unit (
    input  logic      clk,
    input  logic      rst_n,
    bbps_req_if.sink  req,
    bbps_rsp_if.source rsp,
    bbps_cfg_if.sink  cfg
);

    bbps_pkg::cfg_t   cfg_reg;
    bbps_pkg::state_t state_reg;
    bbps_pkg::state_t state_next;
    logic             took_next;
    logic             out_valid_reg;
    logic             accepted_reg;
    logic             buzzer_reg;
    logic             busy_reg;
    logic             in_fire;

    assign cfg.ready = 1'b1;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign in_fire = req.valid && req.ready;

    bbps_step u_step (
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .command (req.command),
        .sound   (req.sound),
        .nxt     (state_next),
        .took    (took_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.beep <= bbps_pkg::BEEP_RST;
            cfg_reg.short_gap <= bbps_pkg::SHORT_GAP_RST;
            cfg_reg.long_gap <= bbps_pkg::LONG_GAP_RST;
            cfg_reg.long_beep <= bbps_pkg::LONG_BEEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bbps_pkg::CFG_BEEP:      cfg_reg.beep <= cfg.data;
                bbps_pkg::CFG_SHORT_GAP: cfg_reg.short_gap <= cfg.data;
                bbps_pkg::CFG_LONG_GAP:  cfg_reg.long_gap <= cfg.data;
                bbps_pkg::CFG_LONG_BEEP: cfg_reg.long_beep <= cfg.data;
                default:                 cfg_reg.beep <= cfg_reg.beep;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            accepted_reg <= took_next;
            buzzer_reg <= state_next.drive;
            busy_reg <= state_next.active;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.accepted = accepted_reg;
    assign rsp.buzzer_on = buzzer_reg;
    assign rsp.busy_res = busy_reg;

    // An idle sequencer keeps the buzzer off with an empty countdown.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.active |-> (!state_reg.drive && state_reg.ticks_left == '0))
        else $error("idle sequencer with buzzer on or countdown loaded");

    // A taken request starts with the initial silence.
    a_accept_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.accepted) |-> (rsp.busy_res && !rsp.buzzer_on))
        else $error("accepted request not busy and silent");

    // Single-beep patterns never advance past their only beep.
    a_single_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.kind == bbps_pkg::KIND_SINGLE || state_reg.kind == bbps_pkg::KIND_FACTORY)
        |-> (state_reg.step <= 3'd1))
        else $error("single-beep pattern stepped too far");

    // A request that finds the block busy leaves the pattern untouched.
    a_busy_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req.command && state_reg.active) |=>
        (state_reg == $past(state_reg) && !rsp.accepted))
        else $error("busy request changed the state");

endmodule

/* tb/buzzer_beep_pattern_sequencer_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the buzzer beep sequencer: random ticks and requests, predicted status.
module buzzer_beep_pattern_sequencer_unit_test;

    localparam logic [bbps_pkg::SOUND_W-1:0] SOUND_BUTTON = 3'd0;
    localparam logic [bbps_pkg::SOUND_W-1:0] SOUND_FACTORY = 3'd4;
    localparam logic [bbps_pkg::SOUND_W-1:0] SOUND_TOP_CODE = 3'd7;
    localparam int ITEM_GOAL = 1850;
    localparam int FINAL_TICKS = 250;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic                         command;
        logic [bbps_pkg::SOUND_W-1:0] sound;
    } beep_item_t;

    typedef struct packed {
        logic accepted;
        logic buzzer_on;
        logic busy;
    } status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bbps_req_if req_ch();
    bbps_rsp_if rsp_ch();
    bbps_cfg_if cfg_ch();

    buzzer_beep_pattern_sequencer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    beep_item_t pending_items[$];
    status_t    expected_status[$];

    bbps_pkg::cfg_t                 lengths;
    bbps_pkg::cfg_t                 plan_cfg;
    logic                           seq_active;
    bbps_pkg::kind_t                seq_kind;
    logic [bbps_pkg::STEP_W-1:0]    seq_step;
    logic [bbps_pkg::TICK_BITS-1:0] seq_left;
    logic                           seq_drive;

    int  n_items_issued = 0;
    int  n_results_checked = 0;
    int  n_errors = 0;
    int  n_taken = 0;
    int  n_refused = 0;
    int  n_settings = 0;
    int  cycle_cnt = 0;
    int  quiet_cycles = 0;
    logic calm;

    assign calm = (cycle_cnt % 1500) >= 1000;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [bbps_pkg::TICK_BITS-1:0] saturate_len(
        input logic [bbps_pkg::REG_W-1:0] v);
        if (v > bbps_pkg::TICK_MAX)
        begin
            return bbps_pkg::TICK_MAX;
        end
        return bbps_pkg::TICK_BITS'(v);
    endfunction

    function automatic void load_step(input logic level,
                                      input logic [bbps_pkg::REG_W-1:0] len);
        seq_drive = level;
        seq_left = saturate_len(len);
        seq_step = seq_step + 1'b1;
    endfunction

    function automatic void end_pattern();
        seq_drive = 1'b0;
        seq_active = 1'b0;
        seq_step = '0;
        seq_left = '0;
    endfunction

    function automatic void next_step();
        case (seq_kind)
            bbps_pkg::KIND_SINGLE, bbps_pkg::KIND_FACTORY:
            begin
                if (seq_step == 0)
                begin
                    load_step(1'b1, (seq_kind == bbps_pkg::KIND_FACTORY) ?
                                    lengths.long_beep : lengths.beep);
                end
                else
                begin
                    end_pattern();
                end
            end
            bbps_pkg::KIND_LOWPWR:
            begin
                if (seq_step == 0 || seq_step == 2)
                begin
                    load_step(1'b1, lengths.beep);
                end
                else if (seq_step == 1)
                begin
                    load_step(1'b0, lengths.short_gap);
                end
                else
                begin
                    end_pattern();
                end
            end
            default:
            begin
                if (!seq_step[0])
                begin
                    load_step(1'b1, lengths.beep);
                end
                else if (seq_step == 1 || seq_step == 5)
                begin
                    load_step(1'b0, lengths.short_gap);
                end
                else if (seq_step == 3)
                begin
                    load_step(1'b0, lengths.long_gap);
                end
                else
                begin
                    end_pattern();
                end
            end
        endcase
    endfunction

    function automatic status_t predict_status(input beep_item_t item);
        status_t r;
        r.accepted = 1'b0;
        if (item.command == bbps_pkg::CMD_REQUEST)
        begin
            if (!seq_active)
            begin
                if (item.sound <= bbps_pkg::SOUND_HIGH_POWER)
                begin
                    seq_kind = bbps_pkg::KIND_SINGLE;
                end
                else if (item.sound == bbps_pkg::SOUND_ERROR)
                begin
                    seq_kind = bbps_pkg::KIND_ERROR;
                end
                else if (item.sound == bbps_pkg::SOUND_LOW_POWER)
                begin
                    seq_kind = bbps_pkg::KIND_LOWPWR;
                end
                else
                begin
                    seq_kind = bbps_pkg::KIND_FACTORY;
                end
                seq_active = 1'b1;
                seq_step = '0;
                seq_left = saturate_len(lengths.beep);
                r.accepted = 1'b1;
            end
        end
        else if (seq_active)
        begin
            if (seq_left <= 1)
            begin
                seq_left = '0;
                next_step();
            end
            else
            begin
                seq_left = seq_left - 1'b1;
            end
        end
        r.buzzer_on = seq_drive;
        r.busy = seq_active;
        return r;
    endfunction

    function automatic int tick_len(input logic [bbps_pkg::REG_W-1:0] v);
        return (saturate_len(v) == 0) ? 1 : int'(saturate_len(v));
    endfunction

    // Ticks from an accepted request until the block is idle again.
    function automatic int pattern_span(input logic [bbps_pkg::SOUND_W-1:0] snd,
                                        input bbps_pkg::cfg_t c);
        int b;
        b = tick_len(c.beep);
        if (snd <= bbps_pkg::SOUND_HIGH_POWER)
        begin
            return 2 * b;
        end
        else if (snd == bbps_pkg::SOUND_ERROR)
        begin
            return 5 * b + 2 * tick_len(c.short_gap) + tick_len(c.long_gap);
        end
        else if (snd == bbps_pkg::SOUND_LOW_POWER)
        begin
            return 3 * b + tick_len(c.short_gap);
        end
        return b + tick_len(c.long_beep);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.command <= bbps_pkg::CMD_TICK;
            req_ch.sound <= '0;
            lengths <= {bbps_pkg::BEEP_RST, bbps_pkg::SHORT_GAP_RST,
                        bbps_pkg::LONG_GAP_RST, bbps_pkg::LONG_BEEP_RST};
            seq_active <= 1'b0;
            seq_kind <= bbps_pkg::KIND_SINGLE;
            seq_step <= '0;
            seq_left <= '0;
            seq_drive <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    bbps_pkg::CFG_BEEP:      lengths.beep = cfg_ch.data;
                    bbps_pkg::CFG_SHORT_GAP: lengths.short_gap = cfg_ch.data;
                    bbps_pkg::CFG_LONG_GAP:  lengths.long_gap = cfg_ch.data;
                    bbps_pkg::CFG_LONG_BEEP: lengths.long_beep = cfg_ch.data;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
            begin
                status_t s;
                s = predict_status({req_ch.command, req_ch.sound});
                expected_status.push_back(s);
                if (req_ch.command == bbps_pkg::CMD_REQUEST)
                begin
                    if (s.accepted)
                    begin
                        n_taken++;
                    end
                    else
                    begin
                        n_refused++;
                    end
                end
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 13))
                begin
                    beep_item_t item;
                    item = pending_items.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.command <= item.command;
                    req_ch.sound <= item.sound;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_bit(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", field, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_results_checked++;
                if (expected_status.size() == 0)
                begin
                    $error("unexpected result: accepted=%0b buzzer_on=%0b busy_res=%0b",
                           rsp_ch.accepted, rsp_ch.buzzer_on, rsp_ch.busy_res);
                    n_errors++;
                end
                else
                begin
                    status_t want;
                    want = expected_status.pop_front();
                    check_bit("accepted", want.accepted, rsp_ch.accepted);
                    check_bit("buzzer_on", want.buzzer_on, rsp_ch.buzzer_on);
                    check_bit("busy_res", want.busy, rsp_ch.busy_res);
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(input logic command, input logic [bbps_pkg::SOUND_W-1:0] snd);
        pending_items.push_back({command, snd});
        n_items_issued++;
    endtask

    task automatic drain();
        while (n_results_checked < n_items_issued)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bbps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bbps_pkg::REG_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_lengths(input logic [bbps_pkg::REG_W-1:0] b,
                                   input logic [bbps_pkg::REG_W-1:0] s,
                                   input logic [bbps_pkg::REG_W-1:0] l,
                                   input logic [bbps_pkg::REG_W-1:0] lb);
        drain();
        write_reg(bbps_pkg::CFG_BEEP, b);
        write_reg(bbps_pkg::CFG_SHORT_GAP, s);
        write_reg(bbps_pkg::CFG_LONG_GAP, l);
        write_reg(bbps_pkg::CFG_LONG_BEEP, lb);
        plan_cfg = {b, s, l, lb};
        n_settings++;
    endtask

    function automatic logic [bbps_pkg::REG_W-1:0] pick_len();
        if ($urandom_range(99) < 15)
        begin
            return bbps_pkg::REG_W'($urandom_range(7, 30));
        end
        return bbps_pkg::REG_W'($urandom_range(0, 6));
    endfunction

    // A request followed by the ticks that carry its pattern to the end, optionally
    // with a refused request inside it or cut short.
    task automatic play_sequence(input logic [bbps_pkg::SOUND_W-1:0] snd, input int refuse_at,
                                 input int extra, input int cut);
        int span;
        span = pattern_span(snd, plan_cfg) + extra;
        if (cut > 0 && cut < span)
        begin
            span = cut;
        end
        queue_item(bbps_pkg::CMD_REQUEST, snd);
        for (int i = 0; i < span; i++)
        begin
            if (i == refuse_at)
            begin
                queue_item(bbps_pkg::CMD_REQUEST, bbps_pkg::SOUND_W'($urandom_range(7)));
            end
            queue_item(bbps_pkg::CMD_TICK, bbps_pkg::SOUND_W'($urandom_range(7)));
        end
    endtask

    task automatic random_traffic(input int budget);
        int stop;
        int roll;
        stop = n_items_issued + budget;
        while (n_items_issued < stop)
        begin
            roll = $urandom_range(99);
            if (roll < 6)
            begin
                for (int k = $urandom_range(1, 8); k > 0; k--)
                begin
                    queue_item(1'($urandom_range(1)), bbps_pkg::SOUND_W'($urandom_range(7)));
                end
            end
            else
            begin
                play_sequence(bbps_pkg::SOUND_W'($urandom_range(7)),
                              (roll < 18) ? $urandom_range(0, 6) : -1,
                              $urandom_range(3),
                              (roll >= 90) ? $urandom_range(1, 10) : 0);
            end
        end
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.command = bbps_pkg::CMD_TICK;
        req_ch.sound = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = bbps_pkg::CFG_BEEP;
        cfg_ch.data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset lengths: a tick while idle, then a full high-power beep with a refused request.
        plan_cfg = {bbps_pkg::BEEP_RST, bbps_pkg::SHORT_GAP_RST,
                    bbps_pkg::LONG_GAP_RST, bbps_pkg::LONG_BEEP_RST};
        queue_item(bbps_pkg::CMD_TICK, SOUND_TOP_CODE);
        play_sequence(bbps_pkg::SOUND_HIGH_POWER, 5, 1, 0);

        program_lengths(bbps_pkg::REG_W'(1), bbps_pkg::REG_W'(1),
                        bbps_pkg::REG_W'(1), bbps_pkg::REG_W'(1));
        queue_item(bbps_pkg::CMD_TICK, SOUND_BUTTON);
        play_sequence(SOUND_BUTTON, 1, 0, 0);
        play_sequence(bbps_pkg::SOUND_ERROR, -1, 0, 0);
        play_sequence(bbps_pkg::SOUND_LOW_POWER, -1, 0, 0);
        play_sequence(SOUND_FACTORY, -1, 0, 0);
        play_sequence(SOUND_TOP_CODE, -1, 0, 0);

        program_lengths('0, '0, '0, '0);
        random_traffic(100);

        while (n_items_issued < ITEM_GOAL - FINAL_TICKS)
        begin
            program_lengths(pick_len(), pick_len(), pick_len(), pick_len());
            random_traffic(150);
        end

        program_lengths('1, '1, '1, '1);
        queue_item(bbps_pkg::CMD_REQUEST, bbps_pkg::SOUND_ERROR);
        repeat (FINAL_TICKS)
            queue_item(bbps_pkg::CMD_TICK, bbps_pkg::SOUND_W'($urandom_range(7)));
        drain();

        if (expected_status.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_status.size());
            n_errors++;
        end
        $display("Checked %0d status results over %0d length settings,", n_results_checked,
                 n_settings);
        $display("with %0d requests taken and %0d refused while busy.", n_taken, n_refused);
        if (n_errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
